### design/bir_pkg.sv
package bir_pkg;

    localparam int DEFAULT_IMAGE_SIZE = 28;

    localparam int COORD_W    = 5;
    localparam int PIX_W      = 8;
    localparam int TRIG_W     = 16;
    localparam int FRAC_BITS  = 14;
    localparam int ONE_Q14    = 16384;
    localparam int OFS_W      = 9;
    localparam int PROD_W     = OFS_W + TRIG_W;
    localparam int POS_W      = PROD_W + 1;
    localparam int WGT_W      = FRAC_BITS + 1;
    localparam int HSUM_W     = PIX_W + FRAC_BITS;
    localparam int FSUM_W     = PIX_W + 2 * FRAC_BITS;
    localparam int NBR        = 4;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_COS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN = 2'd1;

    typedef struct packed {
        logic rd;
        logic wr;
    } store_cmd_t;

endpackage

### design/bilinear_image_rotate.sv
// Rotates a square 8-bit image about its center with bilinear interpolation. A transfer with
// tuser 0 loads one source pixel (loads outside the image are dropped); a transfer with
// tuser 1 requests the output pixel at (col,row) and yields one result: the interpolated
// byte and a flag that is 1 when the rotated point fell inside the source. The rotation
// uses cos/sin in signed Q2.14, written through the configuration port; the user must write
// them only while idle, as the block does not enforce it. A new item is taken every cycle
// unless the output is held; each result passes the input, product, position, store, blend,
// weight and output registers. The rate is set by the image store, split into four banks by
// row and column parity so that all four neighbors are read in the same cycle. Loads write
// at the store stage in order with requests, so a request sees exactly the loads transferred before it.
module bilinear_image_rotate #(
    parameter int IMAGE_SIZE = bir_pkg::DEFAULT_IMAGE_SIZE
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bir_pkg::IN_DATA_W-1:0]     s_tdata,   // col[4:0], row[9:5], pixel_in[17:10]
    input  logic [0:0]                        s_tuser,   // op[0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bir_pkg::OUT_DATA_W-1:0]    m_tdata,   // pixel_out[7:0]
    output logic [0:0]                        m_tuser,   // inside_res[0]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bir_pkg::TRIG_W-1:0]        cfg_data
);
    import bir_pkg::*;

    localparam int CW    = $clog2(IMAGE_SIZE);
    localparam int CTR15 = (IMAGE_SIZE - 1) * ONE_Q14;
    localparam int LIM15 = (IMAGE_SIZE - 1) * 2 * ONE_Q14;
    localparam logic signed [POS_W-1:0] CTR_POS = POS_W'(CTR15);
    localparam logic signed [POS_W-1:0] LIM_POS = POS_W'(LIM15);

    // configuration
    logic signed [TRIG_W-1:0] cos_reg, cos_next;
    logic signed [TRIG_W-1:0] sin_reg, sin_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cos_next = cos_reg;
        sin_next = sin_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_COS: cos_next = cfg_data;
                REG_SIN: sin_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= TRIG_W'(ONE_Q14);
            sin_reg <= '0;
        end
        else
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    // stage enables
    logic en1, en2, en3, en4, en5, en6, en7;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next, v6_next, v7_next;

    assign en7 = !v7_reg || m_tready;
    assign en6 = !v6_reg || en7;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    // stage 1: input register
    logic               op1_reg, op1_next;
    logic [COORD_W-1:0] col1_reg, col1_next;
    logic [COORD_W-1:0] row1_reg, row1_next;
    logic [PIX_W-1:0]   pix1_reg, pix1_next;

    assign v1_next   = s_tvalid;
    assign op1_next  = s_tuser[0];
    assign col1_next = s_tdata[COORD_W-1:0];
    assign row1_next = s_tdata[2*COORD_W-1:COORD_W];
    assign pix1_next = s_tdata[2*COORD_W+PIX_W-1:2*COORD_W];

    // stage 2: centered offsets times cos and sin
    logic signed [OFS_W-1:0]  xo, yo;
    logic signed [PROD_W-1:0] pxc_reg, pxc_next, pys_reg, pys_next;
    logic signed [PROD_W-1:0] pxs_reg, pxs_next, pyc_reg, pyc_next;
    logic                     req2_reg, req2_next, wr2_reg, wr2_next;
    logic [CW-1:0]            col2_reg, col2_next, row2_reg, row2_next;
    logic [PIX_W-1:0]         pix2_reg, pix2_next;

    assign xo = $signed({3'b000, col1_reg, 1'b0}) - $signed(OFS_W'(IMAGE_SIZE - 1));
    assign yo = $signed({3'b000, row1_reg, 1'b0}) - $signed(OFS_W'(IMAGE_SIZE - 1));

    assign v2_next   = v1_reg;
    assign pxc_next  = xo * cos_reg;
    assign pys_next  = yo * sin_reg;
    assign pxs_next  = xo * sin_reg;
    assign pyc_next  = yo * cos_reg;
    assign req2_next = (op1_reg == OP_REQUEST);
    assign wr2_next  = (op1_reg == OP_LOAD) && (9'(col1_reg) < 9'(IMAGE_SIZE))
                       && (9'(row1_reg) < 9'(IMAGE_SIZE));
    assign col2_next = CW'(col1_reg);
    assign row2_next = CW'(row1_reg);
    assign pix2_next = pix1_reg;

    // stage 3: mapped position, inside test, neighbor and fractions
    logic signed [POS_W-1:0] x15, y15;
    logic                    in_c;
    logic                    req3_reg, req3_next, inside3_reg, inside3_next;
    logic [CW-1:0]           x03_reg, x03_next, y03_reg, y03_next;
    logic [FRAC_BITS-1:0]    dx3_reg, dx3_next, dy3_reg, dy3_next;
    logic [PIX_W-1:0]        pix3_reg, pix3_next;

    assign x15  = pxc_reg - pys_reg + CTR_POS;
    assign y15  = pxs_reg + pyc_reg + CTR_POS;
    assign in_c = !x15[POS_W-1] && (x15 < LIM_POS) && !y15[POS_W-1] && (y15 < LIM_POS);

    always_comb
    begin
        v3_next      = v2_reg && (req2_reg || wr2_reg);
        req3_next    = req2_reg;
        inside3_next = req2_reg && in_c;
        dx3_next     = x15[FRAC_BITS:1];
        dy3_next     = y15[FRAC_BITS:1];
        pix3_next    = pix2_reg;
        if (!req2_reg)
        begin
            x03_next = col2_reg;
            y03_next = row2_reg;
        end
        else if (in_c)
        begin
            x03_next = x15[FRAC_BITS+1 +: CW];
            y03_next = y15[FRAC_BITS+1 +: CW];
        end
        else
        begin
            x03_next = '0;
            y03_next = '0;
        end
    end

    // stage 4: banked image store
    store_cmd_t                      cmd;
    logic [NBR-1:0][PIX_W-1:0]       rdata;
    logic                            inside4_reg, inside4_next;
    logic                            x0p4_reg, x0p4_next, y0p4_reg, y0p4_next;
    logic [FRAC_BITS-1:0]            dx4_reg, dx4_next, dy4_reg, dy4_next;

    assign cmd.rd = en4;
    assign cmd.wr = en4 && v3_reg && !req3_reg;

    bir_store #(
        .IMAGE_SIZE (IMAGE_SIZE)
    ) u_store (
        .clk   (clk),
        .cmd   (cmd),
        .x0    (x03_reg),
        .y0    (y03_reg),
        .wdata (pix3_reg),
        .rdata (rdata)
    );

    assign v4_next      = v3_reg && req3_reg;
    assign inside4_next = inside3_reg;
    assign x0p4_next    = x03_reg[0];
    assign y0p4_next    = y03_reg[0];
    assign dx4_next     = dx3_reg;
    assign dy4_next     = dy3_reg;

    // stage 5: blend along x
    logic [PIX_W-1:0]     p00, p10, p01, p11;
    logic [WGT_W-1:0]     ix;
    logic [HSUM_W-1:0]    h0_reg, h0_next, h1_reg, h1_next;
    logic [FRAC_BITS-1:0] dy5_reg, dy5_next;
    logic                 inside5_reg, inside5_next;

    assign p00 = rdata[{y0p4_reg, x0p4_reg}];
    assign p10 = rdata[{y0p4_reg, !x0p4_reg}];
    assign p01 = rdata[{!y0p4_reg, x0p4_reg}];
    assign p11 = rdata[{!y0p4_reg, !x0p4_reg}];
    assign ix  = WGT_W'(ONE_Q14) - WGT_W'(dx4_reg);

    assign v5_next      = v4_reg;
    assign h0_next      = HSUM_W'(p00) * HSUM_W'(ix) + HSUM_W'(p10) * HSUM_W'(dx4_reg);
    assign h1_next      = HSUM_W'(p01) * HSUM_W'(ix) + HSUM_W'(p11) * HSUM_W'(dx4_reg);
    assign dy5_next     = dy4_reg;
    assign inside5_next = inside4_reg;

    // stage 6: weight along y
    logic [WGT_W-1:0]  iy;
    logic [FSUM_W-1:0] m0_reg, m0_next, m1_reg, m1_next;
    logic              inside6_reg, inside6_next;

    assign iy           = WGT_W'(ONE_Q14) - WGT_W'(dy5_reg);
    assign v6_next      = v5_reg;
    assign m0_next      = FSUM_W'(h0_reg) * FSUM_W'(iy);
    assign m1_next      = FSUM_W'(h1_reg) * FSUM_W'(dy5_reg);
    assign inside6_next = inside5_reg;

    // stage 7: output register
    logic [FSUM_W-1:0] fsum;
    logic [PIX_W-1:0]  pix7_reg, pix7_next;
    logic              inside7_reg, inside7_next;

    assign fsum         = m0_reg + m1_reg;
    assign v7_next      = v6_reg;
    assign pix7_next    = inside6_reg ? fsum[2*FRAC_BITS +: PIX_W] : '0;
    assign inside7_next = inside6_reg;

    assign m_tvalid   = v7_reg;
    assign m_tdata    = pix7_reg;
    assign m_tuser[0] = inside7_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= v1_next;
            end
            if (en2)
            begin
                v2_reg <= v2_next;
            end
            if (en3)
            begin
                v3_reg <= v3_next;
            end
            if (en4)
            begin
                v4_reg <= v4_next;
            end
            if (en5)
            begin
                v5_reg <= v5_next;
            end
            if (en6)
            begin
                v6_reg <= v6_next;
            end
            if (en7)
            begin
                v7_reg <= v7_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg  <= op1_next;
            col1_reg <= col1_next;
            row1_reg <= row1_next;
            pix1_reg <= pix1_next;
        end
        if (en2)
        begin
            pxc_reg  <= pxc_next;
            pys_reg  <= pys_next;
            pxs_reg  <= pxs_next;
            pyc_reg  <= pyc_next;
            req2_reg <= req2_next;
            wr2_reg  <= wr2_next;
            col2_reg <= col2_next;
            row2_reg <= row2_next;
            pix2_reg <= pix2_next;
        end
        if (en3)
        begin
            req3_reg    <= req3_next;
            inside3_reg <= inside3_next;
            x03_reg     <= x03_next;
            y03_reg     <= y03_next;
            dx3_reg     <= dx3_next;
            dy3_reg     <= dy3_next;
            pix3_reg    <= pix3_next;
        end
        if (en4)
        begin
            inside4_reg <= inside4_next;
            x0p4_reg    <= x0p4_next;
            y0p4_reg    <= y0p4_next;
            dx4_reg     <= dx4_next;
            dy4_reg     <= dy4_next;
        end
        if (en5)
        begin
            h0_reg      <= h0_next;
            h1_reg      <= h1_next;
            dy5_reg     <= dy5_next;
            inside5_reg <= inside5_next;
        end
        if (en6)
        begin
            m0_reg      <= m0_next;
            m1_reg      <= m1_next;
            inside6_reg <= inside6_next;
        end
        if (en7)
        begin
            pix7_reg    <= pix7_next;
            inside7_reg <= inside7_next;
        end
    end

endmodule

### design/bir_store.sv
module bir_store #(
    parameter int IMAGE_SIZE = bir_pkg::DEFAULT_IMAGE_SIZE
) (
    input  logic                                       clk,
    input  bir_pkg::store_cmd_t                        cmd,
    input  logic [$clog2(IMAGE_SIZE)-1:0]              x0,
    input  logic [$clog2(IMAGE_SIZE)-1:0]              y0,
    input  logic [bir_pkg::PIX_W-1:0]                  wdata,
    output logic [bir_pkg::NBR-1:0][bir_pkg::PIX_W-1:0] rdata
);
    import bir_pkg::*;

    localparam int CW   = $clog2(IMAGE_SIZE);
    localparam int HALF = (IMAGE_SIZE + 1) / 2;
    localparam int BD   = HALF * HALF;
    localparam int AW   = $clog2(BD);

    // one bank per column and row parity, so the four neighbors never share a bank
    for (genvar b = 0; b < NBR; b++)
    begin : g_bank
        localparam logic PX = 1'(b % 2);
        localparam logic PY = 1'(b / 2);

        logic [PIX_W-1:0] bank_mem [BD];
        logic [PIX_W-1:0] rd_reg;
        logic [CW:0]      xs;
        logic [CW:0]      ys;
        logic [AW-1:0]    addr;
        logic             hit;

        assign xs   = {1'b0, x0} + (CW + 1)'(x0[0] != PX);
        assign ys   = {1'b0, y0} + (CW + 1)'(y0[0] != PY);
        assign addr = AW'(ys[CW:1]) * AW'(HALF) + AW'(xs[CW:1]);
        assign hit  = (x0[0] == PX) && (y0[0] == PY);

        always_ff @(posedge clk)
        begin
            if (cmd.wr && hit)
            begin
                bank_mem[addr] <= wdata;
            end
            if (cmd.rd)
            begin
                rd_reg <= bank_mem[addr];
            end
        end

        assign rdata[b] = rd_reg;
    end

endmodule
